// ===== rtl/ftbp_pkg.sv =====
package ftbp_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegRulePresent = 2'd0;
  localparam logic [1:0] RegRuleDir     = 2'd1;
  localparam logic [1:0] RegRate        = 2'd2;
  localparam logic [1:0] RegBurstScale  = 2'd3;

  localparam int unsigned CfgIdxW = 2;

  // Nanoseconds in one second.
  localparam logic [63:0] NsPerSecond = 64'd1000000000;

  // Reciprocal of one second scaled by 2^93 and rounded down.
  localparam logic [63:0] NsRecip = 64'd9903520314283042199;

  typedef struct packed {
    logic        direction;
    logic [63:0] group_key;
    logic [63:0] now_time;
    logic [19:0] length;
  } in_item_t;

  typedef struct packed {
    logic rule_applied;
    logic drop;
    logic untracked;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StCap,
    StSearch,
    StSearchWait,
    StCreate,
    StMul,
    StDiv,
    StUpdate,
    StWrite,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic cap_step;    // one step of the capacity multiply
    logic search_rd;   // issue a read of the search index
    logic search_chk;  // compare the read entry and advance
    logic create;      // take the free slot for a new bucket
    logic mul_step;    // one step of the refill multiply
    logic div_start;   // start the divider
    logic div_step;    // one divider step
    logic update;      // compute tokens and verdict
    logic write;       // write the entry back
    logic untracked;   // record a full table
    logic bypass;      // record an unchecked item
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic applies;
    logic mul_done;
    logic search_last;
    logic hit;
    logic have_free;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/per_flow_token_bucket_policer_core.sv =====
// Channel  Direction  Handshake         Payload
// in       input      in_valid/stall    ftbp_pkg::in_item_t
// out      output     out_valid/stall   ftbp_pkg::out_item_t
// cfg      input      cfg_valid/ready   register index and 32-bit data
//
// One item at a time; a checked item walks the keys with a read state and a
// compare state per entry, then runs the six-step reciprocal divider. Reset
// clears the valid bits, the verdict and the configuration registers at once;
// there is no clearing pass. While the result is stalled, no new item is taken.
module per_flow_token_bucket_policer_core #(
  parameter int unsigned Buckets = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ftbp_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ftbp_pkg::out_item_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ftbp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                cfg_data_i
);

  logic        rule_present_q, rule_dir_q;
  logic [31:0] rate_q, burst_scale_q;
  ftbp_pkg::ctrl_t ctrl;
  ftbp_pkg::stat_t stat;
  logic busy;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_present_q <= 1'b0;
      rule_dir_q     <= 1'b0;
      rate_q         <= '0;
      burst_scale_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ftbp_pkg::RegRulePresent: rule_present_q <= cfg_data_i[0];
        ftbp_pkg::RegRuleDir:     rule_dir_q     <= cfg_data_i[0];
        ftbp_pkg::RegRate:        rate_q         <= cfg_data_i;
        ftbp_pkg::RegBurstScale:  burst_scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ftbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .busy_o      (busy)
  );

  ftbp_dp #(.Buckets(Buckets)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_data_i      (in_data_i),
    .rule_present_i (rule_present_q),
    .rule_dir_i     (rule_dir_q),
    .rate_i         (rate_q),
    .burst_scale_i  (burst_scale_q),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_data_o     (out_data_o)
  );

  // An input transaction is never taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  // A bypassed item never reports a drop or untracked.
  a_unchecked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.rule_applied) |->
      (!out_data_o.drop && !out_data_o.untracked)) else $error("bad unchecked result");

  // Untracked and drop are exclusive.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.drop && out_data_o.untracked))
    else $error("drop with untracked");

  // Busy follows an accepted input.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> busy) else $error("not busy after accept");

endmodule

// ===== rtl/ftbp_ram.sv =====
module ftbp_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ftbp_ctrl.sv =====
module ftbp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  ftbp_pkg::stat_t stat_i,
  output ftbp_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);

  ftbp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftbp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ftbp_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = ftbp_pkg::StCap;
        end
      end
      ftbp_pkg::StCap: begin
        if (!stat_i.applies) begin
          ctrl_o.bypass = 1'b1;
          state_d = ftbp_pkg::StOut;
        end else begin
          ctrl_o.cap_step = 1'b1;
          if (stat_i.mul_done) begin
            ctrl_o.search_rd = 1'b1;
            state_d = ftbp_pkg::StSearchWait;
          end
        end
      end
      ftbp_pkg::StSearch: begin
        ctrl_o.search_rd = 1'b1;
        state_d = ftbp_pkg::StSearchWait;
      end
      ftbp_pkg::StSearchWait: begin
        ctrl_o.search_chk = 1'b1;
        if (stat_i.hit) begin
          state_d = ftbp_pkg::StMul;
        end else if (stat_i.search_last) begin
          state_d = ftbp_pkg::StCreate;
        end else begin
          state_d = ftbp_pkg::StSearch;
        end
      end
      ftbp_pkg::StCreate: begin
        if (stat_i.have_free) begin
          ctrl_o.create = 1'b1;
          state_d = ftbp_pkg::StMul;
        end else begin
          ctrl_o.untracked = 1'b1;
          state_d = ftbp_pkg::StOut;
        end
      end
      ftbp_pkg::StMul: begin
        ctrl_o.mul_step = 1'b1;
        if (stat_i.mul_done) begin
          ctrl_o.div_start = 1'b1;
          state_d = ftbp_pkg::StDiv;
        end
      end
      ftbp_pkg::StDiv: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = ftbp_pkg::StUpdate;
        end
      end
      ftbp_pkg::StUpdate: begin
        ctrl_o.update = 1'b1;
        state_d = ftbp_pkg::StWrite;
      end
      ftbp_pkg::StWrite: begin
        ctrl_o.write = 1'b1;
        state_d = ftbp_pkg::StOut;
      end
      ftbp_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ftbp_pkg::StIdle;
        end
      end
      default: state_d = ftbp_pkg::StIdle;
    endcase
  end

  assign busy_o = (state_q != ftbp_pkg::StIdle);

endmodule

// ===== rtl/ftbp_dp.sv =====
module ftbp_dp #(
  parameter int unsigned Buckets = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftbp_pkg::in_item_t  in_data_i,
  input  logic                rule_present_i,
  input  logic                rule_dir_i,
  input  logic [31:0]         rate_i,
  input  logic [31:0]         burst_scale_i,
  input  ftbp_pkg::ctrl_t     ctrl_i,
  output ftbp_pkg::stat_t     stat_o,
  output ftbp_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned CntW = $clog2(Buckets + 1);
  localparam int unsigned RamW = 192;

  ftbp_pkg::in_item_t  item_q;
  ftbp_pkg::out_item_t res_q;
  logic [Buckets-1:0]  valid_q;
  logic [CntW-1:0]     idx_q;
  logic [IdxW-1:0]     slot_q;
  logic [63:0]         cap_q;
  logic [63:0]         tok_q;
  logic [63:0]         acc_q;
  logic [63:0]         mcand_q;
  logic [1:0]          mstep_q;
  logic [63:0]         quo_q, dvd_q;
  logic [127:0]        prod_q;
  logic [63:0]         qd_q;
  logic [2:0]          dcnt_q;
  logic [63:0]         tokens_q;

  logic [IdxW-1:0]     rd_idx;
  logic [RamW-1:0]     rd_data, wr_data;
  logic [63:0]         e_key, e_stamp, e_tok;
  logic                idx_valid;
  logic [IdxW-1:0]     free_idx;
  logic                have_free;

  assign rd_idx = idx_q[IdxW-1:0];
  assign {e_key, e_stamp, e_tok} = rd_data;
  assign wr_data = {item_q.group_key, item_q.now_time, tokens_q};

  ftbp_ram #(.Width(RamW), .Depth(Buckets)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.write),
    .waddr_i (slot_q),
    .wdata_i (wr_data),
    .raddr_i (rd_idx),
    .rdata_o (rd_data)
  );

  // Lowest free slot by a priority scan of the valid bits.
  always_comb begin
    free_idx  = '0;
    have_free = 1'b0;
    for (int i = Buckets - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx  = IdxW'(i);
        have_free = 1'b1;
      end
    end
  end

  assign idx_valid = valid_q[rd_idx];

  // The 64-bit product is built over two steps, one 32x16 partial product a step.
  logic [47:0] pp;
  logic [15:0] mplier;
  logic [31:0] mcand_lo;
  always_comb begin
    mcand_lo = ctrl_i.cap_step ? burst_scale_i : mcand_q[31:0];
    case (mstep_q)
      2'd0:    mplier = rate_i[15:0];
      2'd1:    mplier = rate_i[31:16];
      default: mplier = 16'd0;
    endcase
    pp = mcand_lo * mplier;
  end

  // Refill amount needs the elapsed low 64 bits times rate: 2 steps of 16 bits.
  logic [79:0] rpp;
  logic [15:0] rmul;
  always_comb begin
    case (mstep_q)
      2'd0:    rmul = rate_i[15:0];
      default: rmul = rate_i[31:16];
    endcase
    rpp = mcand_q * rmul;
  end

  // Division by one second through the scaled reciprocal. Four steps build the
  // high product bits a 16-bit slice at a time, one step multiplies the
  // estimate back, and the last step raises the estimate by one when the
  // remainder still holds a full second.
  logic [15:0] rchunk;
  logic [79:0] dpp;
  logic [34:0] q_est;
  logic [63:0] qd_full;
  logic [63:0] rem;
  always_comb begin
    case (dcnt_q[1:0])
      2'd0:    rchunk = ftbp_pkg::NsRecip[63:48];
      2'd1:    rchunk = ftbp_pkg::NsRecip[47:32];
      2'd2:    rchunk = ftbp_pkg::NsRecip[31:16];
      default: rchunk = ftbp_pkg::NsRecip[15:0];
    endcase
    dpp = dvd_q * rchunk;
  end

  assign q_est   = prod_q[127:93];
  assign qd_full = {29'd0, q_est} * {34'd0, ftbp_pkg::NsPerSecond[29:0]};
  assign rem     = dvd_q - qd_q;

  logic [63:0] sum, capped;
  assign sum    = tok_q + quo_q;
  assign capped = (sum > cap_q) ? cap_q : sum;

  always_comb begin
    stat_o.applies     = rule_present_i && (item_q.direction == rule_dir_i);
    stat_o.mul_done    = (mstep_q == 2'd1);
    stat_o.search_last = (idx_q == CntW'(Buckets - 1));
    stat_o.hit         = idx_valid && (e_key == item_q.group_key);
    stat_o.have_free   = have_free;
    stat_o.div_done    = (dcnt_q == 3'd5);
  end

  // Valid bits and the verdict are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      res_q   <= '0;
    end else begin
      if (ctrl_i.create) begin
        valid_q[free_idx] <= 1'b1;
      end
      if (ctrl_i.load) begin
        res_q <= '0;
      end
      if (ctrl_i.bypass) begin
        res_q <= '0;
      end
      if (ctrl_i.untracked) begin
        res_q <= '{rule_applied: 1'b1, drop: 1'b0, untracked: 1'b1};
      end
      if (ctrl_i.update) begin
        res_q <= '{rule_applied: 1'b1, drop: (capped < 64'(item_q.length)),
                   untracked: 1'b0};
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q    <= in_data_i;
      idx_q     <= '0;
      mstep_q   <= 2'd0;
      acc_q     <= '0;
    end
    if (ctrl_i.cap_step) begin
      if (mstep_q == 2'd0) begin
        acc_q   <= 64'(pp);
        mstep_q <= 2'd1;
        mcand_q <= {32'd0, burst_scale_i};
      end else begin
        cap_q   <= (acc_q + {pp, 16'd0}) >> 2;
        mstep_q <= 2'd0;
        acc_q   <= '0;
      end
    end
    if (ctrl_i.search_chk) begin
      if (stat_o.hit) begin
        slot_q  <= rd_idx;
        tok_q   <= e_tok;
        mcand_q <= item_q.now_time - e_stamp;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (ctrl_i.create) begin
      slot_q    <= free_idx;
      tok_q     <= cap_q;
      mcand_q   <= '0;
    end
    if (ctrl_i.mul_step) begin
      if (mstep_q == 2'd0) begin
        acc_q   <= rpp[63:0];
        mstep_q <= 2'd1;
      end else begin
        acc_q   <= acc_q + {rpp[47:0], 16'd0};
        mstep_q <= 2'd0;
      end
    end
    if (ctrl_i.div_start) begin
      dvd_q  <= acc_q + {rpp[47:0], 16'd0};
      prod_q <= '0;
      quo_q  <= '0;
      dcnt_q <= '0;
    end
    if (ctrl_i.div_step) begin
      if (dcnt_q < 3'd4) begin
        prod_q <= {prod_q[111:0], 16'd0} + {48'd0, dpp};
      end else if (dcnt_q == 3'd4) begin
        quo_q <= {29'd0, q_est};
        qd_q  <= qd_full;
      end else begin
        quo_q <= (rem >= ftbp_pkg::NsPerSecond) ? quo_q + 64'd1 : quo_q;
      end
      dcnt_q <= dcnt_q + 3'd1;
    end
    if (ctrl_i.update) begin
      tokens_q <= (capped < 64'(item_q.length)) ? capped
                                                : capped - 64'(item_q.length);
    end
  end

  assign out_data_o = res_q;

endmodule
